// File: rtl/core/sacl_pkg.sv
// Shared types and constants for the set-associative LRU tag cache.
// No dependencies; imported by sacl_addr_split and set_assoc_cache_lru_tags.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int SBITS_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS      = 2'd2;

  localparam logic [3:0] LINE_SIZE_RESET = 4'd5;
  localparam logic [3:0] SET_COUNT_RESET = 4'd7;
  localparam logic [2:0] WAYS_RESET      = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/sacl_addr_split.sv
// Address decode for the LRU tag cache: set index, tag and last way to search.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacl_addr_split
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS   = 4,
  parameter int MAX_SETS   = 4096,
  parameter int ADDR_WIDTH = 32,
  parameter int SET_W      = 12,
  parameter int WAY_W      = 2
) (
  input  wire logic [ADDR_WIDTH-1:0] address,
  input  wire logic [3:0]            line_size_log2,
  input  wire logic [3:0]            set_count_log2,
  input  wire logic [2:0]            ways_in_use,
  output logic      [SET_W-1:0]      set_idx,
  output logic      [ADDR_WIDTH-1:0] tag,
  output logic      [WAY_W-1:0]      last_way
);

  localparam int SET_BITS = $clog2(MAX_SETS + 1) - 1;

  logic [ADDR_WIDTH-1:0] line_addr;
  logic [SBITS_W-1:0]    sbits;
  logic [SET_W-1:0]      set_mask;
  logic [4:0]            eff_ways;

  always_comb begin
    line_addr = address >> line_size_log2;
    if (32'(set_count_log2) < SET_BITS) begin
      sbits = SBITS_W'(set_count_log2);
    end else begin
      sbits = SBITS_W'(SET_BITS);
    end
    set_mask = SET_W'((32'd1 << sbits) - 32'd1);
    set_idx  = line_addr[SET_W-1:0] & set_mask;
    tag      = line_addr >> sbits;

    if (ways_in_use == 3'd0) begin
      eff_ways = 5'd1;
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      eff_ways = 5'(MAX_WAYS);
    end else begin
      eff_ways = 5'(ways_in_use);
    end
    last_way = WAY_W'(eff_ways - 5'd1);
  end

endmodule

`default_nettype wire

// File: rtl/core/set_assoc_cache_lru_tags.sv
// Set-associative tag cache with LRU replacement; top level. Uses sacl_pkg, sacl_addr_split.
// An access runs from the accepting edge to the done strobe over W ways, W being ways_in_use
// held to 1..MAX_WAYS: one read, a scan of one way per cycle through a shared tag and stamp
// comparator, and one write-back. The next access is accepted no earlier than the edge that
// ends the strobe.
// After reset a clearing pass writes all MAX_SETS rows, one per cycle, with busy high.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_tags
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS   = 4,
  parameter int MAX_SETS   = 4096,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADDR_WIDTH-1:0] address,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output logic                       miss,
  output logic [1:0]                 way_used,
  output logic [CNT_W-1:0]           access_total,
  output logic [CNT_W-1:0]           miss_total
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ENTRY_W = 1 + ADDR_WIDTH + STAMP_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;

  logic [3:0] line_size_log2;
  logic [3:0] set_count_log2;
  logic [2:0] ways_in_use;

  state_t state;
  state_t state_next;

  logic [ROW_W-1:0] mem [MAX_SETS];
  logic [ROW_W-1:0] rd_row;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  logic [SET_W-1:0]      split_set;
  logic [ADDR_WIDTH-1:0] split_tag;
  logic [WAY_W-1:0]      split_last;

  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [WAY_W-1:0]      last_way;
  logic [WAY_W-1:0]      cur_way;
  logic [SET_W-1:0]      clr_idx;
  logic                  hit_found;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      victim_way;
  logic [STAMP_W-1:0]    oldest;
  logic [CNT_W-1:0]      access_cnt;
  logic [CNT_W-1:0]      miss_cnt;
  logic [CNT_W-1:0]      miss_cnt_next;

  logic [ENTRY_W-1:0]    cur_entry;
  logic                  cur_valid;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic [STAMP_W-1:0]    cur_stamp;
  logic [WAY_W-1:0]      sel_way;
  logic                  accept;

  sacl_addr_split #(
    .MAX_WAYS   (MAX_WAYS),
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .SET_W      (SET_W),
    .WAY_W      (WAY_W)
  ) u_split (
    .address        (address),
    .line_size_log2 (line_size_log2),
    .set_count_log2 (set_count_log2),
    .ways_in_use    (ways_in_use),
    .set_idx        (split_set),
    .tag            (split_tag),
    .last_way       (split_last)
  );

  assign accept    = start && !busy;
  assign cur_entry = rd_row[cur_way * ENTRY_W +: ENTRY_W];
  assign cur_valid = cur_entry[0];
  assign cur_tag   = cur_entry[ADDR_WIDTH:1];
  assign cur_stamp = cur_entry[ENTRY_W-1:ADDR_WIDTH+1];
  assign sel_way   = hit_found ? hit_way : victim_way;

  always_comb begin
    if (!hit_found && miss_cnt != '1) begin
      miss_cnt_next = miss_cnt + CNT_W'(1);
    end else begin
      miss_cnt_next = miss_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size_log2 <= LINE_SIZE_RESET;
      set_count_log2 <= SET_COUNT_RESET;
      ways_in_use    <= WAYS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LINE_SIZE: line_size_log2 <= cfg_data[3:0];
        CFG_SET_COUNT: set_count_log2 <= cfg_data[3:0];
        CFG_WAYS:      ways_in_use    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_W'(MAX_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_way == last_way) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = set_r;
    mem_wdata = rd_row;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
        mem_wdata[sel_way * ENTRY_W +: ENTRY_W] = {access_cnt, tag_r, 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_row <= mem[split_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      access_cnt <= '0;
      miss_cnt   <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (accept && access_cnt != '1) begin
        access_cnt <= access_cnt + CNT_W'(1);
      end
      if (state == ST_UPDATE) begin
        miss_cnt <= miss_cnt_next;
        done     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r     <= split_set;
      tag_r     <= split_tag;
      last_way  <= split_last;
      cur_way   <= '0;
      hit_found <= 1'b0;
    end
    if (state == ST_SCAN) begin
      cur_way <= cur_way + WAY_W'(1);
      if (!hit_found && cur_valid && cur_tag == tag_r) begin
        hit_found <= 1'b1;
        hit_way   <= cur_way;
      end
      if (cur_way == '0 || cur_stamp < oldest) begin
        oldest     <= cur_stamp;
        victim_way <= cur_way;
      end
    end
    if (state == ST_UPDATE) begin
      miss         <= !hit_found;
      way_used     <= 2'(sel_way);
      access_total <= access_cnt;
      miss_total   <= miss_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without a preceding write-back");

  a_miss_le_access: assert property (@(posedge clk) disable iff (rst)
    done |-> miss_total <= access_total)
    else $error("miss count exceeds access count");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR |=> state != ST_CLEAR)
    else $error("clearing pass entered outside reset");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cur_way <= last_way)
    else $error("way scan ran past the last way in use");
`endif

endmodule

`default_nettype wire
